@@ src/pffr_pkg.sv @@
`default_nettype none
package pffr_pkg;

   // Table sizes and field widths
   localparam int NUM_PAGES  = 256;
   localparam int NUM_FRAMES = 64;
   localparam int PAGE_W     = 8;
   localparam int FRAME_W    = 6;
   localparam int FCNT_W     = 7;
   localparam int WORD_W     = 32;
   localparam int ACC_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;

   // Access codes
   localparam logic [ACC_W-1:0] ACC_NONE = 2'd0;
   localparam logic [ACC_W-1:0] ACC_READ = 2'd1;
   localparam logic [ACC_W-1:0] ACC_RW   = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_FREE     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EVICT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UPGRADE  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_SPURIOUS = 2'd3;

   // Victim choice
   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_RAND = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd2;

   localparam logic [FCNT_W-1:0] FRAMES_RESET = 7'd64;
   localparam logic [WORD_W-1:0] SEED_RESET   = 32'd1;
   localparam logic [WORD_W-1:0] LFSR_MASK    = 32'h8020_0003;

   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic [ACC_W-1:0]   access;
   } pm_entry_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [ACC_W-1:0]  access;
   } fo_entry_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic decide;
      logic scan_step;
      logic scan_hit;
      logic ev_fifo;
      logic ev_rand;
      logic take_victim;
      logic unmap;
      logic load;
      logic take_tail;
   } pffr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [ACC_W-1:0] access;
      logic             scan_free;
      logic             scan_last;
      logic             rem_done;
      logic             mode;
   } pffr_stat_type;

   function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
      return (v == {WORD_W{1'b1}}) ? v : v + WORD_W'(1);
   endfunction

   function automatic logic [WORD_W-1:0] lfsr_next(input logic [WORD_W-1:0] s);
      return s[0] ? ((s >> 1) ^ LFSR_MASK) : (s >> 1);
   endfunction

endpackage
`default_nettype wire

@@ src/pffr_rem.sv @@
`default_nettype none
module pffr_rem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          short_op,
   input  wire logic [pffr_pkg::WORD_W-1:0]   dividend,
   input  wire logic [pffr_pkg::FCNT_W-1:0]   divisor,
   output logic                               done,
   output logic [pffr_pkg::FRAME_W-1:0]       remainder
);
   import pffr_pkg::*;

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic [WORD_W-1:0]  shift_ff, shift_in;
   logic [FRAME_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [FCNT_W-1:0]  trial;
   logic [FCNT_W-1:0]  diff;

   // One quotient bit a cycle, restoring
   assign trial = {rem_ff, shift_ff[WORD_W-1]};
   assign diff  = trial - divisor;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = short_op ? {dividend[FCNT_W-1:0], {(WORD_W-FCNT_W){1'b0}}} : dividend;
         rem_in   = '0;
         cnt_in   = short_op ? CNT_W'(FCNT_W) : CNT_W'(WORD_W);
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= divisor) ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("remainder unit still running at done");

endmodule
`default_nettype wire

@@ src/pffr_datapath.sv @@
`default_nettype none
module pffr_datapath (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pffr_pkg::pffr_cmd_type          cmd,
   output pffr_pkg::pffr_stat_type              stat,
   input  wire logic [pffr_pkg::PAGE_W-1:0]     req_fault_page,
   input  wire logic                            csr_we,
   input  wire logic [pffr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pffr_pkg::WORD_W-1:0]     csr_wdata,
   output logic [pffr_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pffr_pkg::FRAME_W-1:0]         rsp_mapped_frame,
   output logic [pffr_pkg::ACC_W-1:0]           rsp_new_access,
   output logic [pffr_pkg::PAGE_W-1:0]          rsp_victim_page,
   output logic                                 rsp_victim_writeback,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_faults_total,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_disk_reads_total,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_disk_writes_total
);
   import pffr_pkg::*;

   // Memories
   pm_entry_type       page_map_ff    [NUM_PAGES];
   fo_entry_type       frame_owner_ff [NUM_FRAMES];
   logic [FRAME_W-1:0] fifo_ring_ff   [NUM_FRAMES];

   logic [NUM_PAGES-1:0]  pm_valid_ff, pm_valid_in;
   logic [NUM_FRAMES-1:0] fo_valid_ff, fo_valid_in;

   // Registered read data
   pm_entry_type       pm_q_ff;
   logic               pm_qv_ff;
   fo_entry_type       fo_q_ff;
   logic               fo_qv_ff;
   logic [FRAME_W-1:0] ring_q_ff;

   // Configuration and control state
   logic               mode_ff, mode_in;
   logic [FCNT_W-1:0]  afr_ff, afr_in;
   logic [WORD_W-1:0]  lfsr_ff, lfsr_in;
   logic [FRAME_W-1:0] head_ff, head_in;
   logic [FRAME_W-1:0] tail_ff, tail_in;
   logic [WORD_W-1:0]  fault_ff, fault_in;
   logic [WORD_W-1:0]  read_ff, read_in;
   logic [WORD_W-1:0]  write_ff, write_in;

   // Per-item payload
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [FRAME_W-1:0]  scan_ff, scan_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ACC_W-1:0]    access_ff, access_in;
   logic [PAGE_W-1:0]   victim_ff, victim_in;
   logic                wb_ff, wb_in;

   // Memory write ports
   logic               pm_we;
   logic [PAGE_W-1:0]  pm_waddr;
   pm_entry_type       pm_wdata;
   logic               fo_we;
   logic [FRAME_W-1:0] fo_waddr;
   fo_entry_type       fo_wdata;
   logic               fifo_we;

   // Remainder unit hookup
   logic               rem_start;
   logic               rem_short;
   logic [WORD_W-1:0]  rem_dividend;
   logic               rem_done;
   logic [FRAME_W-1:0] rem_value;

   logic [FCNT_W-1:0]  n_count;
   logic [ACC_W-1:0]   access_cur;
   logic [WORD_W-1:0]  lfsr_step;
   logic [FCNT_W-1:0]  head_inc;
   logic [FCNT_W-1:0]  tail_inc;
   logic               victim_wb;

   // Clamp the frame count to 1..NUM_FRAMES
   assign n_count = (afr_ff == '0) ? FCNT_W'(1) :
                    (afr_ff > FCNT_W'(NUM_FRAMES)) ? FCNT_W'(NUM_FRAMES) : afr_ff;

   assign access_cur = pm_qv_ff ? pm_q_ff.access : ACC_NONE;
   assign lfsr_step  = lfsr_next(lfsr_ff);
   assign head_inc   = {1'b0, head_ff} + FCNT_W'(1);
   assign tail_inc   = {1'b0, tail_ff} + FCNT_W'(1);
   assign victim_wb  = (mode_ff == MODE_FIFO) || (fo_qv_ff && fo_q_ff.access == ACC_RW);

   pffr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .short_op  (rem_short),
      .dividend  (rem_dividend),
      .divisor   (n_count),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // Next state per command
   always_comb begin
      mode_in      = mode_ff;
      afr_in       = afr_ff;
      lfsr_in      = lfsr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fault_in     = fault_ff;
      read_in      = read_ff;
      write_in     = write_ff;
      page_in      = page_ff;
      scan_in      = scan_ff;
      frame_in     = frame_ff;
      status_in    = status_ff;
      access_in    = access_ff;
      victim_in    = victim_ff;
      wb_in        = wb_ff;
      pm_we        = 1'b0;
      pm_waddr     = page_ff;
      pm_wdata     = '{frame: frame_ff, access: ACC_READ};
      fo_we        = 1'b0;
      fo_waddr     = frame_ff;
      fo_wdata     = '{page: page_ff, access: ACC_READ};
      fifo_we      = 1'b0;
      rem_start    = 1'b0;
      rem_short    = 1'b1;
      rem_dividend = WORD_W'(head_inc);

      if (cmd.accept) begin
         page_in = req_fault_page;
      end

      // Classify the fault; upgrade or report spurious in place
      if (cmd.decide) begin
         fault_in  = sat_inc(fault_ff);
         scan_in   = '0;
         victim_in = '0;
         wb_in     = 1'b0;
         case (access_cur)
            ACC_NONE: begin
               access_in = ACC_READ;
            end
            ACC_READ: begin
               status_in = ST_UPGRADE;
               frame_in  = pm_q_ff.frame;
               access_in = ACC_RW;
               pm_we     = 1'b1;
               pm_wdata  = '{frame: pm_q_ff.frame, access: ACC_RW};
               fo_we     = 1'b1;
               fo_waddr  = pm_q_ff.frame;
               fo_wdata  = '{page: page_ff, access: ACC_RW};
            end
            default: begin
               status_in = ST_SPURIOUS;
               frame_in  = pm_q_ff.frame;
               access_in = ACC_RW;
            end
         endcase
      end

      if (cmd.scan_step) begin
         scan_in = scan_ff + FRAME_W'(1);
      end

      if (cmd.scan_hit) begin
         frame_in  = scan_ff;
         status_in = ST_FREE;
      end

      // Launch the victim pick: ring head or random draw
      if (cmd.ev_fifo) begin
         rem_start    = 1'b1;
         rem_short    = 1'b1;
         rem_dividend = WORD_W'(head_inc);
      end

      if (cmd.ev_rand) begin
         lfsr_in      = lfsr_step;
         rem_start    = 1'b1;
         rem_short    = 1'b0;
         rem_dividend = lfsr_step;
      end

      if (cmd.take_victim) begin
         status_in = ST_EVICT;
         if (mode_ff == MODE_FIFO) begin
            frame_in = ring_q_ff;
            head_in  = rem_value;
         end else begin
            frame_in = rem_value;
         end
      end

      // Unmap the page that owned the victim frame
      if (cmd.unmap) begin
         victim_in = fo_qv_ff ? fo_q_ff.page : '0;
         wb_in     = victim_wb;
         if (victim_wb) begin
            write_in = sat_inc(write_ff);
         end
         pm_we    = 1'b1;
         pm_waddr = fo_qv_ff ? fo_q_ff.page : '0;
         pm_wdata = '{frame: frame_ff, access: ACC_NONE};
      end

      // Map the page read-only into the chosen frame
      if (cmd.load) begin
         read_in   = sat_inc(read_ff);
         access_in = ACC_READ;
         pm_we     = 1'b1;
         pm_waddr  = page_ff;
         pm_wdata  = '{frame: frame_ff, access: ACC_READ};
         fo_we     = 1'b1;
         fo_waddr  = frame_ff;
         fo_wdata  = '{page: page_ff, access: ACC_READ};
         if (mode_ff == MODE_FIFO) begin
            fifo_we      = 1'b1;
            rem_start    = 1'b1;
            rem_short    = 1'b1;
            rem_dividend = WORD_W'(tail_inc);
         end
      end

      if (cmd.take_tail) begin
         tail_in = rem_value;
      end

      // Register writes
      if (csr_we) begin
         case (csr_index)
            CSR_MODE:   mode_in = csr_wdata[0];
            CSR_FRAMES: afr_in  = csr_wdata[FCNT_W-1:0];
            CSR_SEED:   lfsr_in = (csr_wdata == '0) ? SEED_RESET : csr_wdata;
            default:    mode_in = mode_ff;
         endcase
      end
   end

   // Valid bits track entries written since reset
   always_comb begin
      pm_valid_in = pm_valid_ff;
      fo_valid_in = fo_valid_ff;
      if (pm_we) begin
         pm_valid_in[pm_waddr] = 1'b1;
      end
      if (fo_we) begin
         fo_valid_in[fo_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_FIFO;
         afr_ff      <= FRAMES_RESET;
         lfsr_ff     <= SEED_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         fault_ff    <= '0;
         read_ff     <= '0;
         write_ff    <= '0;
         pm_valid_ff <= '0;
         fo_valid_ff <= '0;
      end else begin
         mode_ff     <= mode_in;
         afr_ff      <= afr_in;
         lfsr_ff     <= lfsr_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         fault_ff    <= fault_in;
         read_ff     <= read_in;
         write_ff    <= write_in;
         pm_valid_ff <= pm_valid_in;
         fo_valid_ff <= fo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      scan_ff   <= scan_in;
      frame_ff  <= frame_in;
      status_ff <= status_in;
      access_ff <= access_in;
      victim_ff <= victim_in;
      wb_ff     <= wb_in;
   end

   // Page table: one write port, read at accept
   always_ff @(posedge clock) begin
      if (pm_we) begin
         page_map_ff[pm_waddr] <= pm_wdata;
      end
      if (cmd.accept) begin
         pm_q_ff  <= page_map_ff[req_fault_page];
         pm_qv_ff <= pm_valid_ff[req_fault_page];
      end
   end

   // Frame table: read at the current frame every cycle
   always_ff @(posedge clock) begin
      if (fo_we) begin
         frame_owner_ff[fo_waddr] <= fo_wdata;
      end
      fo_q_ff  <= frame_owner_ff[frame_ff];
      fo_qv_ff <= fo_valid_ff[frame_ff];
   end

   // Order ring: push at tail, read at head
   always_ff @(posedge clock) begin
      if (fifo_we) begin
         fifo_ring_ff[tail_ff] <= frame_ff;
      end
      ring_q_ff <= fifo_ring_ff[head_ff];
   end

   assign stat.access    = access_cur;
   assign stat.scan_free = !fo_valid_ff[scan_ff];
   assign stat.scan_last = ({1'b0, scan_ff} == (n_count - FCNT_W'(1)));
   assign stat.rem_done  = rem_done;
   assign stat.mode      = mode_ff;

   assign rsp_status            = status_ff;
   assign rsp_mapped_frame      = frame_ff;
   assign rsp_new_access        = access_ff;
   assign rsp_victim_page       = victim_ff;
   assign rsp_victim_writeback  = wb_ff;
   assign rsp_faults_total      = fault_ff;
   assign rsp_disk_reads_total  = read_ff;
   assign rsp_disk_writes_total = write_ff;

   a_load_marks_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> fo_valid_ff[frame_ff])
      else $error("loaded frame not marked in use");

endmodule
`default_nettype wire

@@ src/pffr_ctrl.sv @@
`default_nettype none
module pffr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output logic                         rsp_valid,
   output pffr_pkg::pffr_cmd_type       cmd,
   input  wire pffr_pkg::pffr_stat_type stat
);
   import pffr_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECIDE    = 4'd1;
   localparam logic [3:0] S_SCAN      = 4'd2;
   localparam logic [3:0] S_EV_START  = 4'd3;
   localparam logic [3:0] S_EV_WAIT   = 4'd4;
   localparam logic [3:0] S_OWNER_RD  = 4'd5;
   localparam logic [3:0] S_UNMAP     = 4'd6;
   localparam logic [3:0] S_LOAD      = 4'd7;
   localparam logic [3:0] S_TAIL_WAIT = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0] state_ff, state_in;

   // Sequence one fault through the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = (stat.access == ACC_NONE) ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            if (stat.scan_free) begin
               cmd.scan_hit = 1'b1;
               state_in     = S_LOAD;
            end else if (stat.scan_last) begin
               state_in = S_EV_START;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_EV_START: begin
            cmd.ev_fifo = (stat.mode == MODE_FIFO);
            cmd.ev_rand = (stat.mode == MODE_RAND);
            state_in    = S_EV_WAIT;
         end
         S_EV_WAIT: begin
            if (stat.rem_done) begin
               cmd.take_victim = 1'b1;
               state_in        = S_OWNER_RD;
            end
         end
         S_OWNER_RD: begin
            state_in = S_UNMAP;
         end
         S_UNMAP: begin
            cmd.unmap = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = (stat.mode == MODE_FIFO) ? S_TAIL_WAIT : S_DONE;
         end
         S_TAIL_WAIT: begin
            if (stat.rem_done) begin
               cmd.take_tail = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted fault did not start work");

   a_beat_then_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("result beat not followed by idle");

endmodule
`default_nettype wire

@@ src/page_fault_frame_replacer_top.sv @@
`default_nettype none
// Page-fault frame replacer. Pulse start with req_fault_page while busy is low;
// one result beat follows on rsp_valid for a single cycle, and the receiver
// must take it then. An upgrade or a spurious fault ends after the classify
// step. A fault on an unmapped page that lands in a free frame is loaded
// there; in FIFO mode the ring tail is then updated through the serial
// remainder unit. With no free frame the scan checks all n active frames and
// an eviction follows: a 7-bit remainder for the ring head in FIFO mode, and
// in random mode the 32-bit draw reduced modulo the frame count one bit a
// cycle. The frame table scan and the shared bit-serial remainder unit are
// the slow parts of a fault. Write configuration only while busy is low.
module page_fault_frame_replacer_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [pffr_pkg::PAGE_W-1:0]     req_fault_page,
   output logic                                 rsp_valid,
   output logic [pffr_pkg::STATUS_W-1:0]        rsp_status,
   output logic [pffr_pkg::FRAME_W-1:0]         rsp_mapped_frame,
   output logic [pffr_pkg::ACC_W-1:0]           rsp_new_access,
   output logic [pffr_pkg::PAGE_W-1:0]          rsp_victim_page,
   output logic                                 rsp_victim_writeback,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_faults_total,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_disk_reads_total,
   output logic [pffr_pkg::WORD_W-1:0]          rsp_disk_writes_total,
   input  wire logic                            csr_we,
   input  wire logic [pffr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pffr_pkg::WORD_W-1:0]     csr_wdata
);
   import pffr_pkg::*;

   pffr_cmd_type  cmd;
   pffr_stat_type stat;

   pffr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   pffr_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_fault_page        (req_fault_page),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_status            (rsp_status),
      .rsp_mapped_frame      (rsp_mapped_frame),
      .rsp_new_access        (rsp_new_access),
      .rsp_victim_page       (rsp_victim_page),
      .rsp_victim_writeback  (rsp_victim_writeback),
      .rsp_faults_total      (rsp_faults_total),
      .rsp_disk_reads_total  (rsp_disk_reads_total),
      .rsp_disk_writes_total (rsp_disk_writes_total)
   );

endmodule
`default_nettype wire

@@ bench/page_fault_frame_replacer_top_test.sv @@
`timescale 1ns / 1ps

module page_fault_frame_replacer_top_test;
   import pffr_pkg::*;

   // Register index the block does not implement
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FRAME_W-1:0]  frame;
      logic [ACC_W-1:0]    access;
      logic [PAGE_W-1:0]   victim;
      logic                writeback;
      logic [WORD_W-1:0]   faults;
      logic [WORD_W-1:0]   reads;
      logic [WORD_W-1:0]   writes;
   } fault_outcome_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic [PAGE_W-1:0]    req_fault_page = '0;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_wdata = '0;

   logic                 busy;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [FRAME_W-1:0]   rsp_mapped_frame;
   logic [ACC_W-1:0]     rsp_new_access;
   logic [PAGE_W-1:0]    rsp_victim_page;
   logic                 rsp_victim_writeback;
   logic [WORD_W-1:0]    rsp_faults_total;
   logic [WORD_W-1:0]    rsp_disk_reads_total;
   logic [WORD_W-1:0]    rsp_disk_writes_total;

   // Predicted page and frame tables
   logic [FRAME_W-1:0] page_frame   [NUM_PAGES]  = '{default: '0};
   logic [ACC_W-1:0]   page_access  [NUM_PAGES]  = '{default: ACC_NONE};
   logic [PAGE_W-1:0]  frame_page   [NUM_FRAMES] = '{default: '0};
   logic [ACC_W-1:0]   frame_access [NUM_FRAMES] = '{default: ACC_NONE};
   logic [FRAME_W-1:0] load_order   [NUM_FRAMES] = '{default: '0};
   bit                 load_seen    [NUM_FRAMES] = '{default: 1'b0};
   int unsigned        evict_ptr = 0;
   int unsigned        load_ptr  = 0;
   logic [WORD_W-1:0]  draw_state = SEED_RESET;
   logic [WORD_W-1:0]  fault_cnt  = '0;
   logic [WORD_W-1:0]  read_cnt   = '0;
   logic [WORD_W-1:0]  write_cnt  = '0;
   logic               cfg_mode   = MODE_FIFO;
   logic [FCNT_W-1:0]  cfg_frames = FRAMES_RESET;

   fault_outcome_type pending_outcomes [$];
   int                mismatches = 0;
   int                status_seen [4] = '{default: 0};
   int                writebacks = 0;

   page_fault_frame_replacer_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_fault_page        (req_fault_page),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_mapped_frame      (rsp_mapped_frame),
      .rsp_new_access        (rsp_new_access),
      .rsp_victim_page       (rsp_victim_page),
      .rsp_victim_writeback  (rsp_victim_writeback),
      .rsp_faults_total      (rsp_faults_total),
      .rsp_disk_reads_total  (rsp_disk_reads_total),
      .rsp_disk_writes_total (rsp_disk_writes_total),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] bump(input logic [WORD_W-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   // Clamp the frame count register to the range the tables support
   function automatic int unsigned frames_in_use();
      if (cfg_frames == 0) return 1;
      if (cfg_frames > NUM_FRAMES) return NUM_FRAMES;
      return cfg_frames;
   endfunction

   // Work out one fault and advance the predicted tables
   function automatic fault_outcome_type resolve_fault(input logic [PAGE_W-1:0] page);
      fault_outcome_type o;
      int unsigned       n;
      int unsigned       f;
      bit                found;
      o = '0;
      n = frames_in_use();
      f = 0;
      fault_cnt = bump(fault_cnt);
      if (page_access[page] == ACC_NONE) begin
         found = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!found && frame_access[i] == ACC_NONE) begin
               f = i;
               found = 1'b1;
            end
         end
         o.status = ST_FREE;
         if (!found) begin
            o.status = ST_EVICT;
            if (cfg_mode == MODE_FIFO) begin
               f = load_order[evict_ptr % NUM_FRAMES];
               o.writeback = 1'b1;
               evict_ptr = (evict_ptr + 1) % n;
            end else begin
               draw_state = draw_state[0] ? ((draw_state >> 1) ^ LFSR_MASK) : (draw_state >> 1);
               f = draw_state % n;
               o.writeback = (frame_access[f] == ACC_RW);
            end
            // unmap whatever page the frame table names, stale or not
            o.victim = frame_page[f];
            if (o.writeback) write_cnt = bump(write_cnt);
            page_frame[o.victim] = FRAME_W'(f);
            page_access[o.victim] = ACC_NONE;
            frame_access[f] = ACC_NONE;
         end
         read_cnt = bump(read_cnt);
         if (cfg_mode == MODE_FIFO) begin
            load_order[load_ptr % NUM_FRAMES] = FRAME_W'(f);
            load_seen[load_ptr % NUM_FRAMES] = 1'b1;
            load_ptr = (load_ptr + 1) % n;
         end
         o.access = ACC_READ;
         page_frame[page] = FRAME_W'(f);
         page_access[page] = ACC_READ;
         frame_page[f] = page;
         frame_access[f] = ACC_READ;
      end else if (page_access[page] == ACC_READ) begin
         o.status = ST_UPGRADE;
         f = page_frame[page];
         o.access = ACC_RW;
         page_access[page] = ACC_RW;
         frame_page[f] = page;
         frame_access[f] = ACC_RW;
      end else begin
         o.status = ST_SPURIOUS;
         f = page_frame[page];
         o.access = ACC_RW;
      end
      o.frame = FRAME_W'(f);
      o.faults = fault_cnt;
      o.reads = read_cnt;
      o.writes = write_cnt;
      status_seen[o.status]++;
      writebacks += o.writeback;
      return o;
   endfunction

   // True when a FIFO eviction would read a ring slot never loaded
   function automatic bit reads_unwritten_slot(input logic [PAGE_W-1:0] page);
      int unsigned n;
      n = frames_in_use();
      if (cfg_mode != MODE_FIFO || page_access[page] != ACC_NONE) return 1'b0;
      for (int i = 0; i < n; i++) begin
         if (frame_access[i] == ACC_NONE) return 1'b0;
      end
      return !load_seen[evict_ptr % NUM_FRAMES];
   endfunction

   // A working set near the frame count for 45 of 100 draws, some mapped pages, some noise
   function automatic logic [PAGE_W-1:0] draw_page(input int unsigned base,
                                                   input int unsigned n);
      int unsigned sel;
      int unsigned f;
      sel = $urandom_range(0, 99);
      if (sel < 45) return PAGE_W'(base + $urandom_range(0, 2 * n + 1));
      if (sel < 75) begin
         f = $urandom_range(0, NUM_FRAMES - 1);
         if (frame_access[f] != ACC_NONE) return frame_page[f];
      end
      return PAGE_W'($urandom);
   endfunction

   // Write one register while the block is idle; leave the enable high
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      if (!csr_we) csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (busy);
      case (idx)
         CSR_MODE:   cfg_mode = data[0];
         CSR_FRAMES: cfg_frames = data[FCNT_W-1:0];
         CSR_SEED:   draw_state = (data == '0) ? SEED_RESET : data;
         default: ;
      endcase
   endtask

   // Send one fault beat; a nonzero gap drops start and idles before the next
   task automatic raise_fault(input logic [PAGE_W-1:0] page, input int unsigned gap);
      if (csr_we) csr_we <= 1'b0;
      if (!start) start <= 1'b1;
      req_fault_page <= page;
      do @(posedge clock); while (busy);
      pending_outcomes.push_back(resolve_fault(page));
      if (gap > 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1)) begin
            do @(posedge clock); while (busy);
         end
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off until every expected beat has arrived and the block is free
   task automatic settle_faults();
      if (start) start <= 1'b0;
      if (csr_we) csr_we <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0 || busy);
   endtask

   task automatic test_free_and_upgrade();
      write_reg(CSR_FRAMES, 32'd2);
      raise_fault(8'h00, $urandom_range(0, 11));
      raise_fault(8'h00, $urandom_range(0, 11));
      raise_fault(8'h00, $urandom_range(0, 11));
      raise_fault(8'hFF, $urandom_range(0, 11));
   endtask

   task automatic test_fifo_eviction();
      settle_faults();
      write_reg(CSR_MODE, 32'(MODE_FIFO));
      raise_fault(8'h80, $urandom_range(0, 11));
      raise_fault(8'hFF, $urandom_range(0, 11));
      raise_fault(8'h01, $urandom_range(0, 11));
      raise_fault(8'h55, $urandom_range(0, 11));
   endtask

   // Zero seed loads as one; an all-ones seed is tried too
   task automatic test_random_eviction();
      settle_faults();
      write_reg(CSR_MODE, 32'(MODE_RAND));
      write_reg(CSR_SEED, 32'h0);
      raise_fault(8'h07, $urandom_range(0, 11));
      raise_fault(8'h07, $urandom_range(0, 11));
      raise_fault(8'hC8, $urandom_range(0, 11));
      raise_fault(8'hAA, $urandom_range(0, 11));
      settle_faults();
      write_reg(CSR_SEED, 32'hFFFF_FFFF);
      raise_fault(8'h07, $urandom_range(0, 11));
      raise_fault(8'h33, $urandom_range(0, 11));
   endtask

   // Frame count zero acts as one, above the table size acts as the table size
   task automatic test_frame_limits();
      settle_faults();
      write_reg(CSR_MODE, 32'(MODE_FIFO));
      write_reg(CSR_FRAMES, 32'd0);
      raise_fault(8'h09, $urandom_range(0, 11));
      raise_fault(8'h09, $urandom_range(0, 11));
      settle_faults();
      write_reg(CSR_FRAMES, 32'd127);
      raise_fault(8'h0A, $urandom_range(0, 11));
      raise_fault(8'h0B, $urandom_range(0, 11));
   endtask

   task automatic test_spare_index();
      settle_faults();
      write_reg(CSR_SPARE, $urandom);
      raise_fault(8'h0A, $urandom_range(0, 11));
   endtask

   task automatic test_random_traffic();
      int unsigned       plan [10];
      int unsigned       n;
      int unsigned       base;
      int unsigned       run_len;
      int unsigned       gap;
      int unsigned       tries;
      logic [WORD_W-1:0] noise;
      logic [PAGE_W-1:0] page;
      plan = '{1, 2, 3, 5, 8, 13, 0, 64, 127, 4};
      plan[9] = $urandom_range(1, NUM_FRAMES);
      for (int ph = 0; ph < 10; ph++) begin
         settle_faults();
         // junk in the unused upper bits of some writes
         noise = $urandom_range(0, 1) ? $urandom : '0;
         write_reg(CSR_MODE, (noise & ~32'h1) | 32'(ph % 2));
         noise = $urandom_range(0, 1) ? $urandom : '0;
         write_reg(CSR_FRAMES, (noise & ~32'h7F) | 32'(plan[ph]));
         case ($urandom_range(0, 3))
            0: write_reg(CSR_SEED, 32'h0);
            1: write_reg(CSR_SEED, 32'hFFFF_FFFF);
            2: write_reg(CSR_SEED, $urandom);
            default: ;
         endcase
         n = frames_in_use();
         base = $urandom_range(0, NUM_PAGES - 1);
         run_len = 0;
         for (int k = 0; k < 75; k++) begin
            page = draw_page(base, n);
            tries = 0;
            while (reads_unwritten_slot(page) && tries < 64) begin
               page = draw_page(base, n);
               tries++;
            end
            if (reads_unwritten_slot(page)) continue;
            // back-to-back stretches between randomly idle ones
            if (run_len == 0 && $urandom_range(0, 9) == 0) run_len = $urandom_range(5, 20);
            if (run_len > 0) begin
               gap = 0;
               run_len--;
            end else begin
               gap = $urandom_range(0, 11);
            end
            raise_fault(page, gap);
            if ($urandom_range(0, 49) == 0) settle_faults();
         end
      end
   endtask

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin : check_outcomes
      fault_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with nothing expected: status %0d frame %0d",
                   rsp_status, rsp_mapped_frame);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_mapped_frame !== want.frame) begin
               $error("mapped_frame: expected %0d, actual %0d", want.frame, rsp_mapped_frame);
               mismatches++;
            end
            if (rsp_new_access !== want.access) begin
               $error("new_access: expected %0d, actual %0d", want.access, rsp_new_access);
               mismatches++;
            end
            if (rsp_victim_page !== want.victim) begin
               $error("victim_page: expected %0d, actual %0d", want.victim, rsp_victim_page);
               mismatches++;
            end
            if (rsp_victim_writeback !== want.writeback) begin
               $error("victim_writeback: expected %0d, actual %0d",
                      want.writeback, rsp_victim_writeback);
               mismatches++;
            end
            if (rsp_faults_total !== want.faults) begin
               $error("faults_total: expected %0d, actual %0d", want.faults, rsp_faults_total);
               mismatches++;
            end
            if (rsp_disk_reads_total !== want.reads) begin
               $error("disk_reads_total: expected %0d, actual %0d",
                      want.reads, rsp_disk_reads_total);
               mismatches++;
            end
            if (rsp_disk_writes_total !== want.writes) begin
               $error("disk_writes_total: expected %0d, actual %0d",
                      want.writes, rsp_disk_writes_total);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_free_and_upgrade();
      test_fifo_eviction();
      test_random_eviction();
      test_frame_limits();
      test_spare_index();
      test_random_traffic();
      settle_faults();
      repeat (150) @(posedge clock);
      $display("Handled %0d faults: %0d free loads, %0d evictions, %0d upgrades, %0d spurious",
               fault_cnt, status_seen[ST_FREE], status_seen[ST_EVICT],
               status_seen[ST_UPGRADE], status_seen[ST_SPURIOUS]);
      $display("Victim writebacks %0d across FIFO and random choice, frame counts 0 to 127",
               writebacks);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
